// ===== rtl/core/assert_macros.svh =====
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define LIS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define LIS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lis_pkg.sv =====
// Shared constants, field layout and controller/datapath interface types.
`default_nettype none

package lis_pkg;

    // Default sizes
    localparam int unsigned DEF_MAX_SEGMENTS = 16;
    localparam int unsigned DEF_MAX_VALUES   = 16;
    localparam int unsigned DEF_INDEX_BITS   = 16;

    // Fixed field widths
    localparam int unsigned ACTION_W      = 2;
    localparam int unsigned INDEX_FIELD_W = 16;
    localparam int unsigned SLOT_W        = 2;
    localparam int unsigned VALUE_W       = 4;
    localparam int unsigned WIDE_W        = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD_VALUE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_SEGMENT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY       = 2'd2;

    // Input item layout in s_tdata
    localparam int unsigned S_START_INDEX_LSB = 0;
    localparam int unsigned S_START_SLOT_LSB  = 16;
    localparam int unsigned S_END_INDEX_LSB   = 18;
    localparam int unsigned S_END_SLOT_LSB    = 34;
    localparam int unsigned S_VALUE_LSB       = 36;
    localparam int unsigned S_PHI_LSB         = 40;
    localparam int unsigned S_TDATA_W         = 48;

    // Result item layout in m_tdata
    localparam int unsigned M_FIELDS_W = 44;
    localparam int unsigned M_TDATA_W  = 48;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic val_add;
        logic set_full;
        logic ins_start;
        logic ins_shift;
        logic ins_place;
        logic scan_start;
        logic scan_step;
        logic val_read;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                val_full;
        logic                seg_full;
        logic                seg_empty;
        logic                seg_gt;
        logic                ptr_is_one;
        logic                scan_last;
        logic                out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lis_ctrl.sv =====
// Controller state machine sequencing adds, sorted inserts and queries.
`default_nettype none

module lis_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire lis_pkg::sts_t sts,
    output lis_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_CMP,
        ST_INS_LAST,
        ST_QRY_SCAN,
        ST_QRY_VAL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (sts.action)
                    lis_pkg::ACT_ADD_VALUE: begin
                        if (sts.val_full) begin
                            cmd.set_full = 1'b1;
                        end else begin
                            cmd.val_add = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    lis_pkg::ACT_ADD_SEGMENT: begin
                        if (sts.seg_full) begin
                            cmd.set_full = 1'b1;
                            state_next   = ST_FINISH;
                        end else begin
                            cmd.ins_start = 1'b1;
                            state_next    = sts.seg_empty ? ST_INS_LAST : ST_INS_CMP;
                        end
                    end
                    lis_pkg::ACT_QUERY: begin
                        if (sts.seg_empty) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_QRY_SCAN;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            // walk down from the tail, moving entries that start later
            ST_INS_CMP: begin
                if (sts.seg_gt) begin
                    cmd.ins_shift = 1'b1;
                    if (sts.ptr_is_one) begin
                        state_next = ST_INS_LAST;
                    end
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_INS_LAST: begin
                cmd.ins_place = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_QRY_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_QRY_VAL;
                end
            end
            ST_QRY_VAL: begin
                cmd.val_read = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lis_datapath.sv =====
// Datapath: segment and value memories, counters, scan logic and result register.
`default_nettype none

module lis_datapath #(
    parameter int unsigned MAX_SEGMENTS = lis_pkg::DEF_MAX_SEGMENTS,
    parameter int unsigned MAX_VALUES   = lis_pkg::DEF_MAX_VALUES,
    parameter int unsigned INDEX_BITS   = lis_pkg::DEF_INDEX_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [lis_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [lis_pkg::ACTION_W-1:0]    s_tuser,
    input  wire logic                            m_tready,
    input  wire lis_pkg::cmd_t                   cmd,
    output lis_pkg::sts_t                        sts,
    output logic                                 m_tvalid,
    output logic [lis_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int unsigned KEY_W     = INDEX_BITS + 2;
    localparam int unsigned SEG_W     = 2 * KEY_W + lis_pkg::VALUE_W;
    localparam int unsigned VAL_W     = KEY_W + 1;
    localparam int unsigned SEG_IDX_W = $clog2(MAX_SEGMENTS);
    localparam int unsigned SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned VAL_IDX_W = $clog2(MAX_VALUES);
    localparam int unsigned VAL_CNT_W = $clog2(MAX_VALUES + 1);
    localparam int unsigned VID_CMP_W =
        (VAL_CNT_W > lis_pkg::VALUE_W) ? VAL_CNT_W : lis_pkg::VALUE_W;
    localparam int unsigned PAD_W     = lis_pkg::M_TDATA_W - lis_pkg::M_FIELDS_W;

    // Index truncated to INDEX_BITS, slot appended below it
    function automatic logic [KEY_W-1:0] make_key(
        input logic [lis_pkg::INDEX_FIELD_W-1:0] idx,
        input logic [lis_pkg::SLOT_W-1:0]        slot
    );
        logic [lis_pkg::WIDE_W-1:0] wide;
        wide = lis_pkg::WIDE_W'(idx);
        return {wide[INDEX_BITS-1:0], slot};
    endfunction

    // Memories: segment entry is {start, end, value}, value entry is {key, phi}
    logic [SEG_W-1:0] seg_mem [MAX_SEGMENTS];
    logic [VAL_W-1:0] val_mem [MAX_VALUES];

    // Item registers
    logic [lis_pkg::ACTION_W-1:0] action_reg;
    logic [KEY_W-1:0]             skey_reg;
    logic [KEY_W-1:0]             ekey_reg;
    logic [lis_pkg::VALUE_W-1:0]  vnum_reg;
    logic                         phi_reg;

    // Control and scan registers
    logic [SEG_CNT_W-1:0]         seg_count_reg, seg_count_next;
    logic [VAL_CNT_W-1:0]         val_count_reg, val_count_next;
    logic [SEG_IDX_W-1:0]         ptr_reg, ptr_next;
    logic                         live_reg, live_next;
    logic                         found_reg, found_next;
    logic [lis_pkg::VALUE_W-1:0]  vid_reg, vid_next;
    logic                         full_reg, full_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [lis_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Registered read data
    logic [SEG_W-1:0]             rd_seg_reg;
    logic [VAL_W-1:0]             rd_val_reg;

    logic [SEG_IDX_W-1:0]         seg_rd_addr;
    logic [SEG_CNT_W-1:0]         seg_count_m1;
    logic [SEG_CNT_W-1:0]         ptr_ext;
    logic [KEY_W-1:0]             rd_start;
    logic [KEY_W-1:0]             rd_end;
    logic [lis_pkg::VALUE_W-1:0]  rd_value;
    logic                         hit;
    logic                         vid_ok;
    logic [VID_CMP_W-1:0]         vid_ext;
    logic [VAL_IDX_W-1:0]         val_rd_addr;
    logic [KEY_W-1:0]             new_skey;
    logic [KEY_W-1:0]             new_ekey;

    // Result fields
    logic [KEY_W-1:0]             def_key;
    logic                         def_phi;
    logic [lis_pkg::WIDE_W-1:0]   def_index_wide;
    logic [lis_pkg::INDEX_FIELD_W-1:0] res_def_index;
    logic [lis_pkg::SLOT_W-1:0]   res_def_slot;
    logic                         res_def_phi;
    logic [lis_pkg::VALUE_W-1:0]  res_vid;
    logic [lis_pkg::INDEX_FIELD_W-1:0] res_reach_index;
    logic [lis_pkg::SLOT_W-1:0]   res_reach_slot;
    logic [lis_pkg::M_TDATA_W-1:0] result;

    assign new_skey = make_key(s_tdata[lis_pkg::S_START_INDEX_LSB +: lis_pkg::INDEX_FIELD_W],
                               s_tdata[lis_pkg::S_START_SLOT_LSB +: lis_pkg::SLOT_W]);
    assign new_ekey = make_key(s_tdata[lis_pkg::S_END_INDEX_LSB +: lis_pkg::INDEX_FIELD_W],
                               s_tdata[lis_pkg::S_END_SLOT_LSB +: lis_pkg::SLOT_W]);

    // Fields of the entry read last cycle
    assign rd_value = rd_seg_reg[lis_pkg::VALUE_W-1:0];
    assign rd_end   = rd_seg_reg[lis_pkg::VALUE_W +: KEY_W];
    assign rd_start = rd_seg_reg[lis_pkg::VALUE_W + KEY_W +: KEY_W];

    assign hit    = (rd_start <= skey_reg) && (skey_reg < rd_end);
    assign vid_ok = VID_CMP_W'(rd_value) < VID_CMP_W'(val_count_reg);

    assign seg_count_m1 = seg_count_reg - SEG_CNT_W'(1);
    assign ptr_ext      = SEG_CNT_W'(ptr_reg);
    assign vid_ext      = VID_CMP_W'(vid_reg);
    assign val_rd_addr  = vid_ext[VAL_IDX_W-1:0];

    // Segment read address
    always_comb begin
        seg_rd_addr = ptr_reg;
        if (cmd.ins_start) begin
            seg_rd_addr = seg_count_m1[SEG_IDX_W-1:0];
        end else if (cmd.ins_shift) begin
            seg_rd_addr = ptr_reg - SEG_IDX_W'(2);
        end else if (cmd.scan_start) begin
            seg_rd_addr = '0;
        end else if (cmd.scan_step) begin
            seg_rd_addr = ptr_reg + SEG_IDX_W'(1);
        end
    end

    // Next values of counters, pointer and scan results
    always_comb begin
        seg_count_next = seg_count_reg;
        val_count_next = val_count_reg;
        ptr_next       = ptr_reg;
        live_next      = live_reg;
        found_next     = found_reg;
        vid_next       = vid_reg;
        full_next      = full_reg;
        m_tvalid_next  = m_tvalid_reg;

        if (cmd.capture) begin
            live_next  = 1'b0;
            found_next = 1'b0;
            vid_next   = '0;
            full_next  = 1'b0;
        end
        if (cmd.set_full) begin
            full_next = 1'b1;
        end
        if (cmd.val_add) begin
            val_count_next = val_count_reg + VAL_CNT_W'(1);
        end
        if (cmd.ins_start) begin
            ptr_next = seg_count_reg[SEG_IDX_W-1:0];
        end
        if (cmd.ins_shift) begin
            ptr_next = ptr_reg - SEG_IDX_W'(1);
        end
        if (cmd.ins_place) begin
            seg_count_next = seg_count_reg + SEG_CNT_W'(1);
        end
        if (cmd.scan_start) begin
            ptr_next = '0;
        end
        // first containing segment with a defined value wins
        if (cmd.scan_step) begin
            ptr_next = ptr_reg + SEG_IDX_W'(1);
            if (hit) begin
                live_next = 1'b1;
                if (!found_reg && vid_ok) begin
                    found_next = 1'b1;
                    vid_next   = rd_value;
                end
            end
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    // Result fields from the value read
    assign def_key        = rd_val_reg[VAL_W-1:1];
    assign def_phi        = rd_val_reg[0];
    assign def_index_wide = lis_pkg::WIDE_W'(def_key[KEY_W-1:2]);

    always_comb begin
        res_vid         = '0;
        res_def_index   = '0;
        res_def_slot    = '0;
        res_def_phi     = 1'b0;
        res_reach_index = '0;
        res_reach_slot  = '0;
        if (found_reg) begin
            res_vid       = vid_reg;
            res_def_index = def_index_wide[lis_pkg::INDEX_FIELD_W-1:0];
            res_def_slot  = def_key[lis_pkg::SLOT_W-1:0];
            res_def_phi   = def_phi;
            if (!def_phi) begin
                res_reach_index = def_index_wide[lis_pkg::INDEX_FIELD_W-1:0];
                res_reach_slot  = def_key[lis_pkg::SLOT_W-1:0];
            end
        end
    end

    assign result = {{PAD_W{1'b0}}, full_reg, res_reach_slot, res_reach_index, res_def_phi,
                     res_def_slot, res_def_index, res_vid, found_reg, live_reg};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_count_reg <= '0;
            val_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            seg_count_reg <= seg_count_next;
            val_count_reg <= val_count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        live_reg  <= live_next;
        found_reg <= found_next;
        vid_reg   <= vid_next;
        full_reg  <= full_next;
        if (cmd.capture) begin
            action_reg <= s_tuser;
            skey_reg   <= new_skey;
            ekey_reg   <= new_ekey;
            vnum_reg   <= s_tdata[lis_pkg::S_VALUE_LSB +: lis_pkg::VALUE_W];
            phi_reg    <= s_tdata[lis_pkg::S_PHI_LSB];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= result;
        end
    end

    // Segment memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.ins_shift) begin
            seg_mem[ptr_reg] <= rd_seg_reg;
        end else if (cmd.ins_place) begin
            seg_mem[ptr_reg] <= {skey_reg, ekey_reg, vnum_reg};
        end
        rd_seg_reg <= seg_mem[seg_rd_addr];
    end

    // Value memory
    always_ff @(posedge aclk) begin
        if (cmd.val_add) begin
            val_mem[val_count_reg[VAL_IDX_W-1:0]] <= {skey_reg, phi_reg};
        end
        if (cmd.val_read) begin
            rd_val_reg <= val_mem[val_rd_addr];
        end
    end

    // Status
    assign sts.action     = action_reg;
    assign sts.val_full   = (val_count_reg == VAL_CNT_W'(MAX_VALUES));
    assign sts.seg_full   = (seg_count_reg == SEG_CNT_W'(MAX_SEGMENTS));
    assign sts.seg_empty  = (seg_count_reg == '0);
    assign sts.seg_gt     = (rd_start > skey_reg);
    assign sts.ptr_is_one = (ptr_reg == SEG_IDX_W'(1));
    assign sts.scan_last  = (ptr_ext == seg_count_m1);
    assign sts.out_busy   = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/live_interval_segment_table_unit.sv =====
// Top level of the live interval segment table: controller, datapath and checks.
`default_nettype none

`include "assert_macros.svh"

// Keeps a table of value definitions and a start-ordered table of half-open
// live segments, and answers liveness and reaching-definition queries for a
// program point (index plus slot, ordered B < d < e < r). The operation is
// chosen by s_tuser; every item returns exactly one result item. Items are
// handled one at a time. Adding a segment walks down from the tail past the
// stored segments that start after the new one, and a query walks all the
// stored segments, one entry per cycle through the segment memory's single
// read port. Adding a value, an add dropped on a full table, and an unused
// action code go straight to the result. A finished result waits in the
// output register while the next item is accepted; only the final load of
// that next result waits for it to be taken. A full table drops the add and
// reports table_full.
module live_interval_segment_table_unit #(
    parameter int unsigned MAX_SEGMENTS = lis_pkg::DEF_MAX_SEGMENTS,
    parameter int unsigned MAX_VALUES   = lis_pkg::DEF_MAX_VALUES,
    parameter int unsigned INDEX_BITS   = lis_pkg::DEF_INDEX_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // start_index[15:0], start_slot[17:16], end_index[33:18], end_slot[35:34],
    // value_number[39:36], phi_flag[40], zero[47:41]
    input  wire logic [lis_pkg::S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  wire logic [lis_pkg::ACTION_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // live[0], found[1], value_id[5:2], def_index[21:6], def_slot[23:22],
    // def_is_phi[24], reaching_index[40:25], reaching_slot[42:41],
    // table_full[43], zero[47:44]
    output logic [lis_pkg::M_TDATA_W-1:0]      m_tdata
);

    lis_pkg::cmd_t cmd;
    lis_pkg::sts_t sts;

    lis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lis_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_VALUES   (MAX_VALUES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // A new result never overwrites one still waiting downstream
    `LIS_ASSERT_IMPL(a_load_free, cmd.out_load, !sts.out_busy, "result loaded over a pending item")
    // Once an item is taken, the input stays closed while it is worked on
    `LIS_ASSERT_NEXT(a_busy_after_accept, cmd.capture, !s_tready, "input open during work")
    // A scan is only started on a non-empty segment table
    `LIS_ASSERT_IMPL(a_scan_nonempty, cmd.scan_start, !sts.seg_empty, "scan of empty table")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for live_interval_segment_table_unit.
`default_nettype none

module testbench;

    import lis_pkg::*;

    localparam int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS;
    localparam int unsigned MAX_VALUES   = DEF_MAX_VALUES;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned TAIL_CYCLES  = 40;

    // Action code that the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Slot codes, in program-point order
    localparam logic [SLOT_W-1:0] SLOT_B = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_D = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_E = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_R = 2'd3;

    // Receiver stall modes
    localparam int RX_ALWAYS  = 0;
    localparam int RX_PATTERN = 1;
    localparam int RX_RANDOM  = 2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [INDEX_FIELD_W-1:0] start_index;
        logic [SLOT_W-1:0]        start_slot;
        logic [INDEX_FIELD_W-1:0] end_index;
        logic [SLOT_W-1:0]        end_slot;
        logic [VALUE_W-1:0]       value_number;
        logic                     phi_flag;
    } item_t;

    typedef struct packed {
        logic                     live;
        logic                     found;
        logic [VALUE_W-1:0]       value_id;
        logic [INDEX_FIELD_W-1:0] def_index;
        logic [SLOT_W-1:0]        def_slot;
        logic                     def_is_phi;
        logic [INDEX_FIELD_W-1:0] reaching_index;
        logic [SLOT_W-1:0]        reaching_slot;
        logic                     table_full;
    } result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // start_index[15:0], start_slot[17:16], end_index[33:18], end_slot[35:34],
    // value_number[39:36], phi_flag[40], zero[47:41]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // action[1:0]
    logic [ACTION_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // live[0], found[1], value_id[5:2], def_index[21:6], def_slot[23:22],
    // def_is_phi[24], reaching_index[40:25], reaching_slot[42:41],
    // table_full[43], zero[47:44]
    logic [M_TDATA_W-1:0] m_tdata;

    live_interval_segment_table_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow tables of the block
    logic [17:0]        seg_lo  [MAX_SEGMENTS];
    logic [17:0]        seg_hi  [MAX_SEGMENTS];
    logic [VALUE_W-1:0] seg_val [MAX_SEGMENTS];
    int unsigned        seg_num = 0;
    logic [17:0]        def_key [MAX_VALUES];
    logic               def_phi [MAX_VALUES];
    int unsigned        def_num = 0;

    item_t   pending_items[$];
    result_t expected_results[$];

    // Generator bookkeeping: segment/value adds issued and segment boundaries
    int unsigned gen_segs = 0;
    int unsigned gen_vals = 0;
    logic [17:0] seg_bounds[$];

    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned query_count   = 0;
    int unsigned live_count    = 0;
    int unsigned found_count   = 0;
    int unsigned reject_count  = 0;
    int unsigned idle_cycles   = 0;

    // Apply one item to the shadow tables and return the result it causes
    function automatic result_t table_update_and_lookup(item_t it);
        result_t     r;
        logic [17:0] skey;
        logic [17:0] ekey;
        logic [17:0] dk;
        int unsigned pos;
        int unsigned i;
        r    = '0;
        skey = {it.start_index, it.start_slot};
        ekey = {it.end_index, it.end_slot};
        case (it.action)
            ACT_ADD_VALUE: begin
                if (def_num >= MAX_VALUES) begin
                    r.table_full = 1'b1;
                    reject_count++;
                end else begin
                    def_key[def_num] = skey;
                    def_phi[def_num] = it.phi_flag;
                    def_num++;
                end
            end
            ACT_ADD_SEGMENT: begin
                if (seg_num >= MAX_SEGMENTS) begin
                    r.table_full = 1'b1;
                    reject_count++;
                end else begin
                    // equal starts keep arrival order
                    pos = 0;
                    while (pos < seg_num && seg_lo[pos] <= skey) pos++;
                    for (i = seg_num; i > pos; i--) begin
                        seg_lo[i]  = seg_lo[i-1];
                        seg_hi[i]  = seg_hi[i-1];
                        seg_val[i] = seg_val[i-1];
                    end
                    seg_lo[pos]  = skey;
                    seg_hi[pos]  = ekey;
                    seg_val[pos] = it.value_number;
                    seg_num++;
                end
            end
            ACT_QUERY: begin
                query_count++;
                for (i = 0; i < seg_num; i++) begin
                    if (seg_lo[i] <= skey && skey < seg_hi[i]) begin
                        r.live = 1'b1;
                        // segments naming an undefined value only count for liveness
                        if (!r.found && seg_val[i] < def_num) begin
                            r.found    = 1'b1;
                            r.value_id = seg_val[i];
                        end
                    end
                end
                if (r.live) live_count++;
                if (r.found) begin
                    found_count++;
                    dk           = def_key[r.value_id];
                    r.def_index  = dk[17:2];
                    r.def_slot   = dk[1:0];
                    r.def_is_phi = def_phi[r.value_id];
                    if (!def_phi[r.value_id]) begin
                        r.reaching_index = dk[17:2];
                        r.reaching_slot  = dk[1:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_START_INDEX_LSB +: INDEX_FIELD_W] = it.start_index;
        d[S_START_SLOT_LSB  +: SLOT_W]        = it.start_slot;
        d[S_END_INDEX_LSB   +: INDEX_FIELD_W] = it.end_index;
        d[S_END_SLOT_LSB    +: SLOT_W]        = it.end_slot;
        d[S_VALUE_LSB       +: VALUE_W]       = it.value_number;
        d[S_PHI_LSB]                          = it.phi_flag;
        return d;
    endfunction

    function automatic result_t unpack_result(logic [M_TDATA_W-1:0] d);
        result_t r;
        r.live           = d[0];
        r.found          = d[1];
        r.value_id       = d[5:2];
        r.def_index      = d[21:6];
        r.def_slot       = d[23:22];
        r.def_is_phi     = d[24];
        r.reaching_index = d[40:25];
        r.reaching_slot  = d[42:41];
        r.table_full     = d[43];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Queue one item and track what the generator has issued
    task automatic queue_item(logic [ACTION_W-1:0] action,
                              logic [INDEX_FIELD_W-1:0] sidx, logic [SLOT_W-1:0] sslot,
                              logic [INDEX_FIELD_W-1:0] eidx, logic [SLOT_W-1:0] eslot,
                              logic [VALUE_W-1:0] vnum, logic phi);
        item_t it;
        it.action       = action;
        it.start_index  = sidx;
        it.start_slot   = sslot;
        it.end_index    = eidx;
        it.end_slot     = eslot;
        it.value_number = vnum;
        it.phi_flag     = phi;
        pending_items.insert(pending_items.size(), it);
        if (action == ACT_ADD_SEGMENT && gen_segs < MAX_SEGMENTS) begin
            seg_bounds.insert(seg_bounds.size(), {sidx, sslot});
            seg_bounds.insert(seg_bounds.size(), {eidx, eslot});
            gen_segs++;
        end
        if (action == ACT_ADD_VALUE) gen_vals++;
    endtask

    // Mostly queries near stored boundaries; adds more often while tables have room
    task automatic queue_random_item();
        int unsigned         pick;
        int unsigned         near;
        int unsigned         len;
        int unsigned         seg_thr;
        int unsigned         val_thr;
        logic [INDEX_FIELD_W-1:0] sidx;
        logic [INDEX_FIELD_W-1:0] eidx;
        logic [17:0]         k;
        pick    = $urandom_range(0, 99);
        seg_thr = (gen_segs < MAX_SEGMENTS) ? 9 : 3;
        val_thr = seg_thr + ((gen_vals < MAX_VALUES) ? 5 : 3);
        if (pick < seg_thr) begin
            sidx = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 63)) : 16'($urandom);
            len  = $urandom_range(0, 12);
            // occasionally reversed
            eidx = ($urandom_range(0, 9) == 0) ? sidx - 16'(len) : sidx + 16'(len);
            queue_item(ACT_ADD_SEGMENT, sidx, 2'($urandom), eidx, 2'($urandom),
                       4'($urandom), 1'($urandom));
        end else if (pick < val_thr) begin
            sidx = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
            queue_item(ACT_ADD_VALUE, sidx, 2'($urandom), 16'($urandom), 2'($urandom),
                       4'($urandom), 1'($urandom));
        end else if (pick >= 97) begin
            queue_item(ACT_UNUSED, 16'($urandom), 2'($urandom), 16'($urandom), 2'($urandom),
                       4'($urandom), 1'($urandom));
        end else begin
            near = $urandom_range(0, 9);
            if (seg_bounds.size() > 0 && near < 6)
                k = seg_bounds[$urandom_range(0, seg_bounds.size() - 1)]
                    + 18'($urandom_range(0, 4)) - 18'd2;
            else if (near < 9)
                k = {16'($urandom_range(0, 70)), 2'($urandom)};
            else
                k = 18'($urandom);
            queue_item(ACT_QUERY, k[17:2], k[1:0], 16'($urandom), 2'($urandom),
                       4'($urandom), 1'($urandom));
        end
    endtask

    // Sender: bursts with random gaps
    item_t       cur_item;
    logic        drv_valid_next;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            drv_valid_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(),
                                        table_update_and_lookup(cur_item));
                items_sent++;
                drv_valid_next = 1'b0;
            end
            if (!drv_valid_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= pack_item(cur_item);
                    s_tuser <= cur_item.action;
                    drv_valid_next = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_tvalid <= drv_valid_next;
        end
    end

    // Receiver: stall pattern switched every so often; monitor compares results
    int          rx_mode    = RX_ALWAYS;
    int unsigned rx_cycle   = 0;
    logic [7:0]  rx_pattern = 8'h5b;
    logic        rx_ready_next;
    result_t     got;
    result_t     want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got 0x%0h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("live", want.live, got.live);
                    check_field("found", want.found, got.found);
                    check_field("value_id", want.value_id, got.value_id);
                    check_field("def_index", want.def_index, got.def_index);
                    check_field("def_slot", want.def_slot, got.def_slot);
                    check_field("def_is_phi", want.def_is_phi, got.def_is_phi);
                    check_field("reaching_index", want.reaching_index, got.reaching_index);
                    check_field("reaching_slot", want.reaching_slot, got.reaching_slot);
                    check_field("table_full", want.table_full, got.table_full);
                end
            end
            rx_cycle++;
            if (rx_cycle % 150 == 0) begin
                rx_mode    = $urandom_range(RX_ALWAYS, RX_RANDOM);
                rx_pattern = 8'($urandom) | 8'h01;
            end
            case (rx_mode)
                RX_ALWAYS:  rx_ready_next = 1'b1;
                RX_PATTERN: begin
                    rx_pattern    = {rx_pattern[6:0], rx_pattern[7]};
                    rx_ready_next = rx_pattern[0];
                end
                default:    rx_ready_next = ($urandom_range(0, 2) != 0);
            endcase
            m_tready <= rx_ready_next;
        end
    end

    // Watchdog: no handshake on either side for too long while work is outstanding
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (pending_items.size() == 0 && !s_tvalid && expected_results.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("live_interval_segment_table_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        // Directed: ignored action, empty table, undefined value ids, slot ordering,
        // exclusive ends, equal starts, empty and reversed segments, index extremes
        queue_item(ACT_UNUSED, 16'hffff, SLOT_R, 16'hffff, SLOT_R, 4'hf, 1'b1);
        queue_item(ACT_QUERY, 16'h0000, SLOT_B, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_ADD_SEGMENT, 16'h0000, SLOT_B, 16'h0000, SLOT_R, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'h0000, SLOT_D, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_ADD_VALUE, 16'hffff, SLOT_R, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'h0000, SLOT_D, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_ADD_VALUE, 16'h0000, SLOT_B, 16'h0000, SLOT_B, 4'h0, 1'b1);
        queue_item(ACT_ADD_SEGMENT, 16'hfff0, SLOT_E, 16'hffff, SLOT_R, 4'h1, 1'b0);
        queue_item(ACT_QUERY, 16'hfffe, SLOT_R, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'hffff, SLOT_R, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'hfff0, SLOT_E, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'hfff0, SLOT_D, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_ADD_SEGMENT, 16'h0000, SLOT_B, 16'h0000, SLOT_E, 4'hf, 1'b0);
        queue_item(ACT_ADD_SEGMENT, 16'h0000, SLOT_B, 16'h0000, SLOT_D, 4'h1, 1'b0);
        queue_item(ACT_QUERY, 16'h0000, SLOT_B, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'h0000, SLOT_R, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_ADD_SEGMENT, 16'h000a, SLOT_D, 16'h000a, SLOT_D, 4'h0, 1'b0);
        queue_item(ACT_ADD_SEGMENT, 16'h0014, SLOT_R, 16'h0014, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'h000a, SLOT_D, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_QUERY, 16'h0014, SLOT_E, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_ADD_SEGMENT, 16'h0005, SLOT_E, 16'h0008, SLOT_B, 4'he, 1'b0);
        queue_item(ACT_QUERY, 16'h0006, SLOT_B, 16'h0000, SLOT_B, 4'h0, 1'b0);
        queue_item(ACT_UNUSED, 16'h1234, SLOT_D, 16'h8765, SLOT_E, 4'ha, 1'b0);
        repeat (RANDOM_ITEMS) queue_random_item();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d items: %0d queries, %0d of them live, %0d resolved to a value.",
                 items_sent, query_count, live_count, found_count);
        $display("Adds rejected on a full table: %0d; mismatches: %0d.",
                 reject_count, error_count);
        if (error_count == 0) begin
            $display("live_interval_segment_table_unit test passed");
        end else begin
            $display("live_interval_segment_table_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== live_interval_segment_table_unit.f =====
+incdir+rtl/core
rtl/core/lis_pkg.sv
rtl/core/lis_ctrl.sv
rtl/core/lis_datapath.sv
rtl/core/live_interval_segment_table_unit.sv
tb/testbench.sv
